[design/rvv_pkg.sv]
// Shared types, widths and codes for the round viewport visibility unit.
package rvv_pkg;

  // Default signed coordinate width of the query fields
  localparam int COORD_BITS_DEF = 16;

  // Fixed widths of registers and result fields
  localparam int DIM_W      = 13;  // screen size, doubled center, search columns
  localparam int RAD_W      = 14;  // doubled radius
  localparam int SPAN_W     = 12;  // span result columns
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int SQ_W       = 28;  // squared doubled distances
  localparam int DIFF_W     = 16;  // doubled coordinate difference

  // Register values after reset
  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd480;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [DIM_W-1:0] CENTER_X_RST      = 13'd479;
  localparam logic [DIM_W-1:0] CENTER_Y_RST      = 13'd479;
  localparam logic [RAD_W-1:0] RADIUS_RST        = 14'd480;

  localparam logic [SPAN_W-1:0] SPAN_MAX = '1;

  // Query codes
  typedef enum logic [OP_W-1:0] {
    OP_POINT     = 3'd0,
    OP_AREA_IN   = 3'd1,
    OP_AREA_HIT  = 3'd2,
    OP_CIRCLE_IN = 3'd3,
    OP_BAND      = 3'd4
  } opcode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_CENTER_X      = 3'd2,
    REG_CENTER_Y      = 3'd3,
    REG_RADIUS        = 3'd4
  } cfg_reg_e;

  // Column source for the next point test
  typedef enum logic [2:0] {
    XS_FIRST,
    XS_SECOND,
    XS_CLAMP,
    XS_MID,
    XS_PROBE
  } xsel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_SQUARE,
    ST_CHECK,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_LEFT,
    PH_RIGHT
  } phase_e;

  // Controller to datapath
  typedef struct packed {
    logic  load;
    logic  test;
    xsel_e xsel;
    logic  acc_set;
    logic  acc_clr;
    logic  acc_and;
    logic  left_init;
    logic  right_init;
    logic  search_upd;
    logic  dir_right;
    logic  write;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pre_ok;
    logic            hit;
    logic            search_more;
  } dp_status_t;

  // Clip a search column to the span field range
  function automatic logic [SPAN_W-1:0] sat_span(logic [DIM_W-1:0] v);
    logic [SPAN_W-1:0] r;
    if (v[DIM_W-1]) begin
      r = SPAN_MAX;
    end else begin
      r = v[SPAN_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/round_viewport_visibility_unit.sv]
// Query flow: point, area-intersect and circle queries take one point test, area-inside two,
// and safe band one followed by a left search (up to 12 steps) and a right one (up to 13).
// Throughput: one query at a time; the next transfer is taken once the current one ends,
// and a stalled result holds the next query in its final state until the output frees.
// Rate is set by the shared point test unit; each column probe passes operand, square and
// compare. Reset (rst_ni low, asynchronous) clears control and loads register defaults.
module round_viewport_visibility_unit #(
  parameter int COORD_BITS = rvv_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rvv_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rvv_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Query input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rvv_pkg::OP_W-1:0]        opcode_i,
  input  logic signed [COORD_BITS-1:0]    coord_x1_i,
  input  logic signed [COORD_BITS-1:0]    coord_y1_i,
  input  logic signed [COORD_BITS-1:0]    coord_x2_i,
  input  logic signed [COORD_BITS-1:0]    coord_y2_i,
  input  logic signed [COORD_BITS-1:0]    circle_radius_i,
  // Result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            visible_o,
  output logic [rvv_pkg::SPAN_W-1:0]      span_left_o,
  output logic [rvv_pkg::SPAN_W-1:0]      span_right_o
);

  rvv_pkg::ctl_cmd_t   cmd;
  rvv_pkg::dp_status_t status;

  // Registers accept a write in any cycle
  assign cfg_ready_o = 1'b1;

  rvv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rvv_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .opcode_i        (opcode_i),
    .coord_x1_i      (coord_x1_i),
    .coord_y1_i      (coord_y1_i),
    .coord_x2_i      (coord_x2_i),
    .coord_y2_i      (coord_y2_i),
    .circle_radius_i (circle_radius_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .visible_o       (visible_o),
    .span_left_o     (span_left_o),
    .span_right_o    (span_right_o)
  );

endmodule

[design/rvv_ctrl.sv]
// Query sequencer: steps point tests, corner pairs and the two band searches.
module rvv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  rvv_pkg::dp_status_t status_i,
  output rvv_pkg::ctl_cmd_t   cmd_o
);

  rvv_pkg::state_e state_q, state_d;
  rvv_pkg::phase_e phase_q, phase_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            in_search;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_search = (phase_q == rvv_pkg::PH_LEFT) || (phase_q == rvv_pkg::PH_RIGHT);

  // Next state and phase
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    case (state_q)
      rvv_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rvv_pkg::ST_PRE;
        end
      end
      rvv_pkg::ST_PRE: begin
        phase_d = rvv_pkg::PH_FIRST;
        state_d = status_i.pre_ok ? rvv_pkg::ST_SQUARE : rvv_pkg::ST_FINISH;
      end
      rvv_pkg::ST_SQUARE: begin
        state_d = rvv_pkg::ST_CHECK;
      end
      rvv_pkg::ST_CHECK: begin
        if (in_search) begin
          state_d = rvv_pkg::ST_SEARCH;
        end else if (!status_i.hit) begin
          state_d = rvv_pkg::ST_FINISH;
        end else if (status_i.op == rvv_pkg::OP_AREA_IN && phase_q == rvv_pkg::PH_FIRST) begin
          state_d = rvv_pkg::ST_SQUARE;
          phase_d = rvv_pkg::PH_SECOND;
        end else if (status_i.op == rvv_pkg::OP_BAND) begin
          state_d = rvv_pkg::ST_SEARCH;
          phase_d = rvv_pkg::PH_LEFT;
        end else begin
          state_d = rvv_pkg::ST_FINISH;
        end
      end
      rvv_pkg::ST_SEARCH: begin
        if (status_i.search_more) begin
          state_d = rvv_pkg::ST_SQUARE;
        end else if (phase_q == rvv_pkg::PH_LEFT) begin
          phase_d = rvv_pkg::PH_RIGHT;
        end else begin
          state_d = rvv_pkg::ST_FINISH;
        end
      end
      rvv_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = rvv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rvv_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o      = '0;
    cmd_o.xsel = rvv_pkg::XS_FIRST;
    in_stall_o = 1'b1;
    case (state_q)
      rvv_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      rvv_pkg::ST_PRE: begin
        if (status_i.pre_ok) begin
          cmd_o.acc_set = 1'b1;
          cmd_o.test    = 1'b1;
          case (status_i.op)
            rvv_pkg::OP_AREA_HIT: cmd_o.xsel = rvv_pkg::XS_CLAMP;
            rvv_pkg::OP_BAND:     cmd_o.xsel = rvv_pkg::XS_MID;
            default:              cmd_o.xsel = rvv_pkg::XS_FIRST;
          endcase
        end else begin
          cmd_o.acc_clr = 1'b1;
        end
      end
      rvv_pkg::ST_CHECK: begin
        if (in_search) begin
          cmd_o.search_upd = 1'b1;
          cmd_o.dir_right  = (phase_q == rvv_pkg::PH_RIGHT);
        end else begin
          cmd_o.acc_and = 1'b1;
          if (status_i.hit && status_i.op == rvv_pkg::OP_AREA_IN &&
              phase_q == rvv_pkg::PH_FIRST) begin
            cmd_o.test = 1'b1;
            cmd_o.xsel = rvv_pkg::XS_SECOND;
          end
          if (status_i.hit && status_i.op == rvv_pkg::OP_BAND) begin
            cmd_o.left_init = 1'b1;
          end
        end
      end
      rvv_pkg::ST_SEARCH: begin
        cmd_o.dir_right = (phase_q == rvv_pkg::PH_RIGHT);
        if (status_i.search_more) begin
          cmd_o.test = 1'b1;
          cmd_o.xsel = rvv_pkg::XS_PROBE;
        end else if (phase_q == rvv_pkg::PH_LEFT) begin
          cmd_o.right_init = 1'b1;
        end
      end
      rvv_pkg::ST_FINISH: begin
        cmd_o.write = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Hold a result until the transfer completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.write) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rvv_pkg::ST_IDLE;
      phase_q     <= rvv_pkg::PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/rvv_datapath.sv]
// Registers, query operands, shared point test unit and band search bounds.
module rvv_datapath #(
  parameter int COORD_BITS = rvv_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rvv_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rvv_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [rvv_pkg::OP_W-1:0]            opcode_i,
  input  logic signed [COORD_BITS-1:0]        coord_x1_i,
  input  logic signed [COORD_BITS-1:0]        coord_y1_i,
  input  logic signed [COORD_BITS-1:0]        coord_x2_i,
  input  logic signed [COORD_BITS-1:0]        coord_y2_i,
  input  logic signed [COORD_BITS-1:0]        circle_radius_i,
  input  rvv_pkg::ctl_cmd_t                   cmd_i,
  output rvv_pkg::dp_status_t                 status_o,
  output logic                                visible_o,
  output logic [rvv_pkg::SPAN_W-1:0]          span_left_o,
  output logic [rvv_pkg::SPAN_W-1:0]          span_right_o
);

  // Working width: holds any coordinate and any raster column, with sign
  localparam int CW = ((COORD_BITS > rvv_pkg::RAD_W) ? COORD_BITS : rvv_pkg::RAD_W) + 1;
  localparam int DW = rvv_pkg::DIM_W;

  // Configuration registers
  logic [DW-1:0]               scr_w_q, scr_h_q, cx2_q, cy2_q;
  logic [rvv_pkg::RAD_W-1:0]   rd2_q;

  // Latched query
  logic [rvv_pkg::OP_W-1:0]    op_q;
  logic signed [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q, rad_q;

  // Widened operands
  logic signed [CW-1:0] x1w, y1w, x2w, y2w, radw;
  logic signed [CW-1:0] wdw, htw, pxw, pyw, pxc, pyc, halfr;
  logic [rvv_pkg::RAD_W-1:0] room;

  // Point test operands and square stage
  logic signed [CW-1:0]        x_q, ya_q, yb_q;
  logic [rvv_pkg::RAD_W-1:0]   r_q;
  logic signed [CW-1:0]        x_d, ya_d, yb_d;
  logic [rvv_pkg::RAD_W-1:0]   r_d;
  logic signed [rvv_pkg::DIFF_W-1:0] dx, dya, dyb;
  logic signed [2*rvv_pkg::DIFF_W-1:0] dxp, dyap, dybp;
  logic [2*rvv_pkg::RAD_W-1:0] rp;
  logic                        inr_q;
  logic [rvv_pkg::SQ_W-1:0]    dxsq_q, dyasq_q, dybsq_q, rsq_q;
  logic [rvv_pkg::SQ_W:0]      suma, sumb;
  logic                        hit;

  // Search bounds
  logic [DW-1:0]   lo_q, hi_q, left_q, mid, wm1, m;
  logic [DW:0]     probe_sum;
  logic [DW-1:0]   probe;
  logic            acc_q;
  logic            pre_ok;

  // Result register
  logic                         vis_q;
  logic [rvv_pkg::SPAN_W-1:0]   sl_q, sr_q;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= rvv_pkg::SCREEN_WIDTH_RST;
      scr_h_q <= rvv_pkg::SCREEN_HEIGHT_RST;
      cx2_q   <= rvv_pkg::CENTER_X_RST;
      cy2_q   <= rvv_pkg::CENTER_Y_RST;
      rd2_q   <= rvv_pkg::RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rvv_pkg::REG_SCREEN_WIDTH:  scr_w_q <= cfg_data_i[DW-1:0];
        rvv_pkg::REG_SCREEN_HEIGHT: scr_h_q <= cfg_data_i[DW-1:0];
        rvv_pkg::REG_CENTER_X:      cx2_q   <= cfg_data_i[DW-1:0];
        rvv_pkg::REG_CENTER_Y:      cy2_q   <= cfg_data_i[DW-1:0];
        rvv_pkg::REG_RADIUS:        rd2_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Latch the query on input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      x1_q  <= coord_x1_i;
      y1_q  <= coord_y1_i;
      x2_q  <= coord_x2_i;
      y2_q  <= coord_y2_i;
      rad_q <= circle_radius_i;
    end
  end

  assign x1w   = CW'(x1_q);
  assign y1w   = CW'(y1_q);
  assign x2w   = CW'(x2_q);
  assign y2w   = CW'(y2_q);
  assign radw  = CW'(rad_q);
  assign wdw   = $signed({{(CW-DW){1'b0}}, scr_w_q});
  assign htw   = $signed({{(CW-DW){1'b0}}, scr_h_q});
  assign pxw   = $signed({{(CW-DW+1){1'b0}}, cx2_q[DW-1:1]});
  assign pyw   = $signed({{(CW-DW+1){1'b0}}, cy2_q[DW-1:1]});
  assign halfr = $signed({{(CW-rvv_pkg::RAD_W+1){1'b0}}, rd2_q[rvv_pkg::RAD_W-1:1]});

  // Clamp the circle center into the rectangle
  assign pxc = (pxw < x1w) ? x1w : ((pxw > x2w) ? x2w : pxw);
  assign pyc = (pyw < y1w) ? y1w : ((pyw > y2w) ? y2w : pyw);

  // Radius left for a tested circle; only used when its radius is in bounds
  assign room = rd2_q - {radw[rvv_pkg::RAD_W-2:0], 1'b0};

  // Reject invalid or inverted queries up front
  always_comb begin
    case (op_q)
      rvv_pkg::OP_POINT:     pre_ok = 1'b1;
      rvv_pkg::OP_AREA_IN:   pre_ok = (x1w <= x2w) && (y1w <= y2w);
      rvv_pkg::OP_AREA_HIT:  pre_ok = (x1w <= x2w) && (y1w <= y2w) && !x2w[CW-1] &&
                                      !y2w[CW-1] && (x1w < wdw) && (y1w < htw);
      rvv_pkg::OP_CIRCLE_IN: pre_ok = !radw[CW-1] && (radw <= halfr);
      rvv_pkg::OP_BAND:      pre_ok = !y1w[CW-1] && (y2w < htw) && (y1w <= y2w);
      default:               pre_ok = 1'b0;
    endcase
  end

  // Select the column and row pair of the next test
  always_comb begin
    case (cmd_i.xsel)
      rvv_pkg::XS_FIRST:  x_d = x1w;
      rvv_pkg::XS_SECOND: x_d = x2w;
      rvv_pkg::XS_CLAMP:  x_d = pxc;
      rvv_pkg::XS_MID:    x_d = pxw;
      rvv_pkg::XS_PROBE:  x_d = $signed({{(CW-DW){1'b0}}, probe});
      default:            x_d = x1w;
    endcase
    case (op_q)
      rvv_pkg::OP_AREA_IN, rvv_pkg::OP_BAND: begin
        ya_d = y1w;
        yb_d = y2w;
      end
      rvv_pkg::OP_AREA_HIT: begin
        ya_d = pyc;
        yb_d = pyc;
      end
      default: begin
        ya_d = y1w;
        yb_d = y1w;
      end
    endcase
    r_d = (op_q == rvv_pkg::OP_CIRCLE_IN) ? room : rd2_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.test) begin
      x_q  <= x_d;
      ya_q <= ya_d;
      yb_q <= yb_d;
      r_q  <= r_d;
    end
  end

  // Square the doubled distances; range bits gate the truncated operands
  assign dx  = $signed({2'b00, x_q[DW-1:0], 1'b0})  - $signed({3'b000, cx2_q});
  assign dya = $signed({2'b00, ya_q[DW-1:0], 1'b0}) - $signed({3'b000, cy2_q});
  assign dyb = $signed({2'b00, yb_q[DW-1:0], 1'b0}) - $signed({3'b000, cy2_q});
  assign dxp  = dx * dx;
  assign dyap = dya * dya;
  assign dybp = dyb * dyb;
  assign rp   = r_q * r_q;

  always_ff @(posedge clk_i) begin
    inr_q   <= !x_q[CW-1] && (x_q < wdw) && !ya_q[CW-1] && (ya_q < htw) &&
               !yb_q[CW-1] && (yb_q < htw);
    dxsq_q  <= dxp[rvv_pkg::SQ_W-1:0];
    dyasq_q <= dyap[rvv_pkg::SQ_W-1:0];
    dybsq_q <= dybp[rvv_pkg::SQ_W-1:0];
    rsq_q   <= rp[rvv_pkg::SQ_W-1:0];
  end

  // Compare both rows against the radius
  assign suma = {1'b0, dxsq_q} + {1'b0, dyasq_q};
  assign sumb = {1'b0, dxsq_q} + {1'b0, dybsq_q};
  assign hit  = inr_q && (suma <= {1'b0, rsq_q}) && (sumb <= {1'b0, rsq_q});

  // Band search: probe rounds down on the left pass, up on the right pass
  assign mid       = {1'b0, cx2_q[DW-1:1]};
  assign wm1       = scr_w_q - DW'(1);
  assign m         = x_q[DW-1:0];
  assign probe_sum = {1'b0, lo_q} + {1'b0, hi_q} + {{DW{1'b0}}, cmd_i.dir_right};
  assign probe     = probe_sum[DW:1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.left_init) begin
      lo_q <= '0;
      hi_q <= mid;
    end else if (cmd_i.right_init) begin
      left_q <= lo_q;
      lo_q   <= mid;
      hi_q   <= wm1;
    end else if (cmd_i.search_upd) begin
      if (cmd_i.dir_right) begin
        if (hit) begin
          lo_q <= m;
        end else begin
          hi_q <= m - DW'(1);
        end
      end else begin
        if (hit) begin
          hi_q <= m;
        end else begin
          lo_q <= m + DW'(1);
        end
      end
    end
  end

  // Accumulate the visible flag over the tests of one query
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
    end else if (cmd_i.acc_set) begin
      acc_q <= 1'b1;
    end else if (cmd_i.acc_clr) begin
      acc_q <= 1'b0;
    end else if (cmd_i.acc_and) begin
      acc_q <= acc_q & hit;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      vis_q <= acc_q;
      if (acc_q && op_q == rvv_pkg::OP_BAND) begin
        sl_q <= rvv_pkg::sat_span(left_q);
        sr_q <= rvv_pkg::sat_span(lo_q);
      end else begin
        sl_q <= '0;
        sr_q <= '0;
      end
    end
  end

  assign status_o.op          = op_q;
  assign status_o.pre_ok      = pre_ok;
  assign status_o.hit         = hit;
  assign status_o.search_more = (lo_q < hi_q);

  assign visible_o    = vis_q;
  assign span_left_o  = sl_q;
  assign span_right_o = sr_q;

endmodule
